@@ hdl/lgre_pkg.sv @@
// Shared types and constants of the Life generation row engine.
// No dependencies; imported by every module of the block.
package lgre_pkg;

    localparam int ROW_W   = 64;
    localparam int GRID_W  = 7;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 4;
    localparam int TDATA_W = 72;
    localparam int PAD_W   = TDATA_W - IDX_W - ROW_W;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd10;
    localparam logic [GRID_W-1:0] MIN_SIDE   = 7'd3;
    localparam logic [CNT_W-1:0]  BIRTH      = 4'd3;
    localparam logic [CNT_W-1:0]  SURVIVE    = 4'd2;

    // Neighbourhood of one cell: bit 0 is the column to the left.
    typedef struct packed {
        logic [2:0] above;
        logic [2:0] mid;
        logic [2:0] below;
    } lgre_window_t;

    typedef struct packed {
        logic             frame_last;
        logic             run_last;
        logic [ROW_W-1:0] bits;
        logic [IDX_W-1:0] index;
    } lgre_result_t;

endpackage

@@ hdl/lgre_cell.sv @@
// One lane: B3/S23 rule for a single cell from its 3x3 neighbourhood.
// Depends on lgre_pkg.
module lgre_cell (
    input  lgre_pkg::lgre_window_t win,
    output logic                   alive
);
    import lgre_pkg::*;

    logic [CNT_W-1:0] cnt;

    always_comb begin
        cnt = CNT_W'(win.above[0]) + CNT_W'(win.above[1]) + CNT_W'(win.above[2])
            + CNT_W'(win.mid[0]) + CNT_W'(win.mid[2])
            + CNT_W'(win.below[0]) + CNT_W'(win.below[1]) + CNT_W'(win.below[2]);
        alive = (cnt == BIRTH) || ((cnt == SURVIVE) && win.mid[1]);
    end

endmodule

@@ hdl/lgre_merge.sv @@
// Merging stage: gathers lane outputs into one row, forcing the border dead.
// Depends on lgre_pkg.
module lgre_merge #(
    parameter int MAX_SIDE = 64
) (
    input  logic [MAX_SIDE-1:0]         cells,
    input  logic [lgre_pkg::GRID_W-1:0] side,
    input  logic                        row_ok,
    output logic [lgre_pkg::ROW_W-1:0]  row
);
    import lgre_pkg::*;

    always_comb begin
        row = '0;
        for (int j = 1; j < MAX_SIDE; j++) begin
            row[j] = cells[j] && row_ok && (GRID_W'(j + 1) < side);
        end
    end

endmodule

@@ hdl/life_generation_row_engine.sv @@
// Life generation row engine (B3/S23), one grid row per item.
// First result of an item is registered, offered in the cycle after acceptance.
// One item per cycle while m_tready holds; an end-of-frame item yields two results.
// Reset: grid size 10, row count zero, row history cleared, output empty.
// Depends on lgre_pkg, lgre_cell and lgre_merge.
module life_generation_row_engine #(
    parameter int MAX_SIDE = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lgre_pkg::GRID_W-1:0]   cfg_data,     // grid_size
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lgre_pkg::ROW_W-1:0]    s_tdata,      // row_bits
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lgre_pkg::TDATA_W-1:0]  m_tdata,      // row_index, next_row_bits, pad
    output logic                          m_tlast,      // run_last
    output logic                          m_tuser       // frame_last
);
    import lgre_pkg::*;

    localparam logic [GRID_W-1:0] MAX_N = GRID_W'(MAX_SIDE);

    logic [GRID_W-1:0]   grid_size_reg;
    logic [MAX_SIDE-1:0] hist0_reg, hist1_reg;
    logic [IDX_W-1:0]    row_count_reg, row_count_next;
    lgre_result_t        head_reg, head_next, tail_reg, tail_next;
    logic                head_valid_reg, head_valid_next;
    logic                tail_valid_reg, tail_valid_next;

    logic [GRID_W-1:0]   side_n;
    logic [GRID_W-1:0]   c_inc;
    logic [MAX_SIDE-1:0] col_mask, cur, above, mid;
    logic [MAX_SIDE+1:0] above_x, mid_x, below_x;
    logic [MAX_SIDE-1:0] cells;
    logic [ROW_W-1:0]    merged;
    logic                last, row_ok, has_a, s_fire, m_fire;
    lgre_result_t        res_a, res_b;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (grid_size_reg < MIN_SIDE) begin
            side_n = MIN_SIDE;
        end else if (grid_size_reg > MAX_N) begin
            side_n = MAX_N;
        end else begin
            side_n = grid_size_reg;
        end
        for (int k = 0; k < MAX_SIDE; k++) begin
            col_mask[k] = GRID_W'(k) < side_n;
        end
    end

    assign cur     = s_tdata[MAX_SIDE-1:0] & col_mask;
    assign above   = hist1_reg & col_mask;
    assign mid     = hist0_reg & col_mask;
    assign above_x = {1'b0, above, 1'b0};
    assign mid_x   = {1'b0, mid, 1'b0};
    assign below_x = {1'b0, cur, 1'b0};

    for (genvar g = 0; g < MAX_SIDE; g++) begin : g_lane
        lgre_window_t win;
        assign win.above = above_x[g+2:g];
        assign win.mid   = mid_x[g+2:g];
        assign win.below = below_x[g+2:g];
        lgre_cell u_cell (
            .win   (win),
            .alive (cells[g])
        );
    end

    assign c_inc  = {1'b0, row_count_reg} + GRID_W'(1);
    assign last   = c_inc >= side_n;
    assign row_ok = (row_count_reg >= IDX_W'(2)) && (c_inc <= side_n);
    assign has_a  = row_count_reg != '0;

    lgre_merge #(
        .MAX_SIDE (MAX_SIDE)
    ) u_merge (
        .cells  (cells),
        .side   (side_n),
        .row_ok (row_ok),
        .row    (merged)
    );

    always_comb begin
        res_a.index      = row_count_reg - IDX_W'(1);
        res_a.bits       = merged;
        res_a.run_last   = !last;
        res_a.frame_last = 1'b0;
        res_b.index      = row_count_reg;
        res_b.bits       = '0;
        res_b.run_last   = 1'b1;
        res_b.frame_last = 1'b1;
    end

    assign s_tready = !head_valid_reg || (m_tready && !tail_valid_reg);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = head_valid_reg && m_tready;

    always_comb begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        tail_next       = tail_reg;
        tail_valid_next = tail_valid_reg;
        row_count_next  = row_count_reg;
        if (m_fire) begin
            head_next       = tail_reg;
            head_valid_next = tail_valid_reg;
            tail_valid_next = 1'b0;
        end
        if (s_fire) begin
            row_count_next = last ? '0 : row_count_reg + IDX_W'(1);
            if (has_a) begin
                head_next       = res_a;
                head_valid_next = 1'b1;
                tail_next       = res_b;
                tail_valid_next = last;
            end else if (last) begin
                head_next       = res_b;
                head_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg  <= GRID_RESET;
            row_count_reg  <= '0;
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
            hist0_reg      <= '0;
            hist1_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                grid_size_reg <= cfg_data;
            end
            row_count_reg  <= row_count_next;
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
            if (s_fire) begin
                hist1_reg <= hist0_reg;
                hist0_reg <= cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, head_reg.bits, head_reg.index};
    assign m_tlast  = head_reg.run_last;
    assign m_tuser  = head_reg.frame_last;

endmodule

@@ test/life_generation_row_engine_test.sv @@
// Self-checking bench for the B3/S23 Life row engine: random grids, row by row.
// A scoreboard class predicts every next-generation row; plain tasks drive the input and config ports.
// Depends on lgre_pkg and life_generation_row_engine.
module life_generation_row_engine_test;
    import lgre_pkg::*;

    localparam int SIDE_LIMIT   = 64;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 400;
    localparam int SETTLE       = 6;

    class life_row_scoreboard;
        logic [GRID_W-1:0] side_reg;
        logic [ROW_W-1:0]  row_prev;
        logic [ROW_W-1:0]  row_newest;
        logic [IDX_W-1:0]  row_cnt;
        lgre_result_t      expected_rows[$];
        int                errors;

        function new();
            side_reg   = GRID_RESET;
            row_prev   = '0;
            row_newest = '0;
            row_cnt    = '0;
            errors     = 0;
        endfunction

        function void set_side(logic [GRID_W-1:0] v);
            side_reg = v;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        function int eff_side();
            int n;
            n = side_reg;
            if (n < 3) n = 3;
            if (n > SIDE_LIMIT) n = SIDE_LIMIT;
            return n;
        endfunction

        function logic [ROW_W-1:0] row_mask(int n);
            if (n >= ROW_W) return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        function logic [ROW_W-1:0] next_generation(logic [ROW_W-1:0] above,
                                                   logic [ROW_W-1:0] mid,
                                                   logic [ROW_W-1:0] below,
                                                   int r, int n);
            logic [ROW_W-1:0] res;
            int s;
            res = '0;
            if (r < 1 || r + 2 > n) return res;
            for (int j = 1; j + 1 < n; j++) begin
                s = 0;
                for (int k = -1; k <= 1; k++) begin
                    s += int'(above[j+k]) + int'(below[j+k]);
                end
                s += int'(mid[j-1]) + int'(mid[j+1]);
                if (s == int'(BIRTH) || (s == int'(SURVIVE) && mid[j])) res[j] = 1'b1;
            end
            return res;
        endfunction

        function void note_row(logic [ROW_W-1:0] row);
            int n;
            int c;
            bit last;
            logic [ROW_W-1:0] msk;
            logic [ROW_W-1:0] cur;
            lgre_result_t r;
            n    = eff_side();
            msk  = row_mask(n);
            cur  = row & msk;
            c    = row_cnt;
            last = (c + 1 >= n);
            if (c >= 1) begin
                r.index      = IDX_W'(c - 1);
                r.bits       = next_generation(row_prev & msk, row_newest & msk, cur, c - 1, n);
                r.run_last   = !last;
                r.frame_last = 1'b0;
                expected_rows.push_back(r);
            end
            if (last) begin
                r.index      = IDX_W'(c);
                r.bits       = '0;
                r.run_last   = 1'b1;
                r.frame_last = 1'b1;
                expected_rows.push_back(r);
            end
            row_prev   = row_newest;
            row_newest = cur;
            row_cnt    = last ? '0 : IDX_W'(c + 1);
        endfunction

        function void check_result(logic [TDATA_W-1:0] data, logic tl, logic tu);
            lgre_result_t e;
            logic [IDX_W-1:0] idx;
            logic [ROW_W-1:0] bits;
            logic [PAD_W-1:0] pad;
            idx  = data[IDX_W-1:0];
            bits = data[IDX_W +: ROW_W];
            pad  = data[TDATA_W-1 -: PAD_W];
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row, index %0d bits %h", $time, idx, bits);
                errors++;
                return;
            end
            e = expected_rows.pop_front();
            if (idx !== e.index) begin
                $display("%0t: row_index expected %0d actual %0d", $time, e.index, idx);
                errors++;
            end
            if (bits !== e.bits) begin
                $display("%0t: next_row_bits expected %h actual %h", $time, e.bits, bits);
                errors++;
            end
            if (tl !== e.run_last) begin
                $display("%0t: run_last expected %b actual %b", $time, e.run_last, tl);
                errors++;
            end
            if (tu !== e.frame_last) begin
                $display("%0t: frame_last expected %b actual %b", $time, e.frame_last, tu);
                errors++;
            end
            if (pad !== '0) begin
                $display("%0t: tdata pad expected 0 actual %b", $time, pad);
                errors++;
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [GRID_W-1:0]   cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [ROW_W-1:0]    s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    life_row_scoreboard sb;
    int tx_gap   = 0;
    int tx_burst = 0;
    int rx_stall = 0;
    int rx_burst = 0;
    int rx_seen  = 0;
    bit hold_done = 1'b0;
    int cycles   = 0;

    life_generation_row_engine #(
        .MAX_SIDE(SIDE_LIMIT)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),       // grid_size
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),         // row_bits
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),         // row_index, next_row_bits, pad
        .m_tlast(m_tlast),         // run_last
        .m_tuser(m_tuser)          // frame_last
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check each item, then hold ready low for a drawn stretch, none in a burst, or once a long hold.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tlast, m_tuser);
                rx_seen++;
                if (!hold_done && rx_seen >= HOLD_AT && s_tvalid) begin
                    hold_done = 1'b1;
                    rx_stall  = HOLD_LEN;
                end else if (rx_burst > 0) begin
                    rx_burst--;
                    rx_stall = 0;
                end else begin
                    rx_stall = $urandom_range(0, 14);
                    if ($urandom_range(0, 19) == 0) rx_burst = 30;
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        logic [ROW_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            4: return a & b & c;
            5: return a | b;
            6: return a & b;
            default: return a;
        endcase
    endfunction

    // Called in the step of the previous handshake, so valid stays high back to back.
    task automatic send_row(input logic [ROW_W-1:0] row);
        if (tx_gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (tx_gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_row(row);
        if (tx_burst > 0) begin
            tx_burst--;
            tx_gap = 0;
        end else begin
            tx_gap = $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0) tx_burst = 40;
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_side(input logic [GRID_W-1:0] v);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        sb.set_side(v);
    endtask

    initial begin
        logic [ROW_W-1:0] pattern [10];
        int corner_sides [7];
        int n;
        int count;
        int sent;
        int phase;
        logic [GRID_W-1:0] v;

        sb = new();
        pattern = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h5555_5555_5555_5555, 64'h38, 64'h28, 64'h38,
                    64'h8000_0000_0000_0001, 64'h200, 64'hFFFF_FFFF_FFFF_FFFF};
        corner_sides = '{64, 127, 65, 1, 2, 3, 63};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset side of ten: solid rows, stripes, a ring of eight cells, bits past the side.
        for (int i = 0; i < 10; i++) send_row(pattern[i]);

        // Side below the minimum acts as three.
        write_side(7'd0);
        repeat (3) send_row('1);

        // Shrink the side mid-frame so the next row ends the frame.
        write_side(7'd10);
        repeat (5) send_row(random_row());
        write_side(7'd4);
        repeat (5) send_row(random_row());

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase < 7) v = GRID_W'(corner_sides[phase]);
            else if ($urandom_range(0, 7) == 0) v = GRID_W'($urandom_range(0, 127));
            else v = GRID_W'($urandom_range(3, 16));
            write_side(v);
            n = sb.eff_side();
            count = (n > 20) ? n : n * $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, n - 1);
            repeat (count) send_row(random_row());
            sent += count;
            phase++;
        end

        s_tvalid <= 1'b0;
        wait_drained();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
